### rtl/daily_temperature_summary_defines.svh
// assertion macros shared by the daily temperature summary rtl
`ifndef DAILY_TEMPERATURE_SUMMARY_DEFINES_SVH
`define DAILY_TEMPERATURE_SUMMARY_DEFINES_SVH
`ifndef SYNTH
`define DTS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("dts assertion failed");
`define DTS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("dts assertion failed");
`else
`define DTS_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define DTS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

### rtl/dts_pkg.sv
// shared constants, types and helper functions of the daily temperature summary
package dts_pkg;

	localparam int COUNT_BITS = 16;
	localparam int SUM_BITS   = COUNT_BITS + 12;
	localparam int NUM_BITS   = SUM_BITS + 1;
	localparam int DEN_BITS   = COUNT_BITS + 1;

	localparam int YEAR_W    = 14;
	localparam int MONTH_W   = 4;
	localparam int DAY_W     = 5;
	localparam int HOUR_W    = 5;
	localparam int MIN_W     = 6;
	localparam int SEC_W     = 6;
	localparam int TEMP_W    = 12;
	localparam int CNT_OUT_W = 16;
	localparam int CNTX_W    = COUNT_BITS + CNT_OUT_W;

	localparam logic signed [TEMP_W-1:0] MIN_RESET  = 12'sd1250;
	localparam logic signed [TEMP_W-1:0] MAX_RESET  = -12'sd250;
	localparam logic signed [TEMP_W-1:0] LOW_RESET  = 12'sd150;
	localparam logic signed [TEMP_W-1:0] HIGH_RESET = 12'sd420;

	localparam logic [HOUR_W-1:0] LAST_HOUR = 5'd23;
	localparam logic [MIN_W-1:0]  LAST_MIN  = 6'd59;
	localparam logic [SEC_W-1:0]  LAST_SEC  = 6'd59;
	localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;

	// gregorian cycle, year residue kept below this
	localparam int LEAP_CYCLE = 400;
	localparam int CENTURY    = 100;
	localparam int RES_W      = 9;

	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_LIMIT  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LIMIT = 1'b1;

	typedef struct packed {
		logic done;
		logic leap;
	} leap_st_t;

	typedef struct packed {
		logic              done;
		logic [TEMP_W-1:0] mean;
	} div_st_t;

	typedef struct packed {
		logic [YEAR_W-1:0]    summary_year;
		logic [MONTH_W-1:0]   summary_month;
		logic [DAY_W-1:0]     summary_day;
		logic [TEMP_W-1:0]    max_temp;
		logic [TEMP_W-1:0]    min_temp;
		logic [TEMP_W-1:0]    mean_temp;
		logic [CNT_OUT_W-1:0] sample_count;
		logic                 last_of_run;
	} summary_t;

	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// count shown on the output, clipped to its width
	function automatic logic [CNT_OUT_W-1:0] count_out(input logic [COUNT_BITS-1:0] c);
		logic [CNTX_W-1:0] w;
		logic [CNTX_W-1:0] lim;
		w   = CNTX_W'(c);
		lim = CNTX_W'({CNT_OUT_W{1'b1}});
		return (w > lim) ? {CNT_OUT_W{1'b1}} : w[CNT_OUT_W-1:0];
	endfunction

endpackage

### rtl/dts_if.sv
// sample and summary channel interfaces
interface dts_in_if import dts_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [YEAR_W-1:0]        year;
	logic [MONTH_W-1:0]       month;
	logic [DAY_W-1:0]         day;
	logic [HOUR_W-1:0]        hour;
	logic [MIN_W-1:0]         minute;
	logic [SEC_W-1:0]         second;
	logic signed [TEMP_W-1:0] temperature;
	logic                     end_of_stream;

	modport source (output valid, year, month, day, hour, minute, second, temperature,
		end_of_stream, input ready);
	modport sink (input valid, year, month, day, hour, minute, second, temperature,
		end_of_stream, output ready);
endinterface

interface dts_out_if import dts_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [YEAR_W-1:0]        summary_year;
	logic [MONTH_W-1:0]       summary_month;
	logic [DAY_W-1:0]         summary_day;
	logic signed [TEMP_W-1:0] max_temp;
	logic signed [TEMP_W-1:0] min_temp;
	logic signed [TEMP_W-1:0] mean_temp;
	logic [CNT_OUT_W-1:0]     sample_count;
	logic                     last_of_run;

	modport source (output valid, summary_year, summary_month, summary_day, max_temp,
		min_temp, mean_temp, sample_count, last_of_run, input ready);
	modport sink (input valid, summary_year, summary_month, summary_day, max_temp,
		min_temp, mean_temp, sample_count, last_of_run, output ready);
endinterface

### rtl/dts_leap.sv
// bit-serial leap year check: year residue mod 400, one year bit per cycle
module dts_leap import dts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [YEAR_W-1:0] year,
	output leap_st_t          st
);
	localparam int CNT_W = $clog2(YEAR_W + 1);

	logic [YEAR_W-1:0] yr_q;
	logic [RES_W-1:0]  res_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [RES_W:0]    trial;
	logic [RES_W-1:0]  res_next;

	always_comb begin
		trial = {res_q, yr_q[YEAR_W-1]};
		if (trial >= (RES_W + 1)'(LEAP_CYCLE))
			res_next = RES_W'(trial - (RES_W + 1)'(LEAP_CYCLE));
		else
			res_next = trial[RES_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(YEAR_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			yr_q  <= year;
			res_q <= '0;
		end else if (busy_q) begin
			yr_q  <= {yr_q[YEAR_W-2:0], 1'b0};
			res_q <= res_next;
		end
	end

	// residue mod 4 equals year mod 4; centuries leap only when divisible by 400
	assign st.done = done_q;
	assign st.leap = (res_q[1:0] == 2'b00) && (res_q != RES_W'(CENTURY))
		&& (res_q != RES_W'(2 * CENTURY)) && (res_q != RES_W'(3 * CENTURY));

endmodule

### rtl/dts_div.sv
// bit-serial restoring divider for the rounded day mean
module dts_div import dts_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [SUM_BITS-1:0] sum,
	input  logic [COUNT_BITS-1:0]      count,
	output div_st_t                    st
);
	localparam int CNT_W = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] num_q;
	logic [DEN_BITS-1:0] den_q;
	logic [DEN_BITS-1:0] rem_q;
	logic                neg_q;
	logic                zero_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [SUM_BITS-1:0] mag;
	logic [DEN_BITS:0]   trial;
	logic                ge;
	logic [TEMP_W-1:0]   q;

	always_comb begin
		mag   = sum[SUM_BITS-1] ? SUM_BITS'(~sum + 1'b1) : SUM_BITS'(sum);
		trial = {rem_q, num_q[NUM_BITS-1]};
		ge    = trial >= {1'b0, den_q};
		q     = num_q[TEMP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// numerator 2|sum| + n over 2n rounds halves away from zero
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= {mag, 1'b0} + NUM_BITS'(count);
			den_q  <= {count, 1'b0};
			rem_q  <= '0;
			neg_q  <= sum[SUM_BITS-1];
			zero_q <= (count == '0);
		end else if (busy_q) begin
			rem_q <= ge ? DEN_BITS'(trial - {1'b0, den_q}) : trial[DEN_BITS-1:0];
			num_q <= {num_q[NUM_BITS-2:0], ge};
		end
	end

	assign st.done = done_q;
	assign st.mean = zero_q ? '0 : (neg_q ? TEMP_W'(~q + 1'b1) : q);

endmodule

### rtl/daily_temperature_summary.sv
// Daily temperature summary: per-day max, min, rounded mean and count of samples.
// Samples arrive on the valid/ready channel "samples", one timestamped reading per
// request; day summaries leave on "summaries". Limits are written through
// cfg_we/cfg_index/cfg_data (index 0 low limit, index 1 high limit); the user
// must write them only while idle, which the block itself does not enforce.
// Each request is handled on its own. The leap year check walks the year one bit
// a cycle, and each summary needs a serial divide of 29 steps (COUNT_BITS + 13).
// Summaries sit in an output register; while the receiver stalls a finished
// summary waits there and the next divide result waits in the divider, so no
// request is taken while a divide result is held back.
// Reset clears the day and the output valid flag and sets the limits to 15.0 and
// 42.0 degrees; the block is ready in the first cycle after reset.
`include "daily_temperature_summary_defines.svh"
module daily_temperature_summary import dts_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	dts_in_if.sink                 samples,
	dts_out_if.source              summaries,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [TEMP_W-1:0]      cfg_data
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LEAP = 2'd1;
	localparam logic [1:0] S_EOS  = 2'd2;
	localparam logic [1:0] S_DIV  = 2'd3;

	logic [1:0] state_q;

	logic signed [TEMP_W-1:0] low_q;
	logic signed [TEMP_W-1:0] high_q;

	logic [YEAR_W-1:0]        in_year_q;
	logic [MONTH_W-1:0]       in_month_q;
	logic [DAY_W-1:0]         in_day_q;
	logic [HOUR_W-1:0]        in_hour_q;
	logic [MIN_W-1:0]         in_min_q;
	logic [SEC_W-1:0]         in_sec_q;
	logic signed [TEMP_W-1:0] in_temp_q;
	logic                     in_eos_q;

	logic [YEAR_W-1:0]          stored_year_q;
	logic [MONTH_W-1:0]         stored_month_q;
	logic [DAY_W-1:0]           stored_day_q;
	logic                       have_day_q;
	logic signed [SUM_BITS-1:0] day_sum_q;
	logic signed [TEMP_W-1:0]   day_min_q;
	logic signed [TEMP_W-1:0]   day_max_q;
	logic [COUNT_BITS-1:0]      day_count_q;

	logic [YEAR_W-1:0]        res_year_q;
	logic [MONTH_W-1:0]       res_month_q;
	logic [DAY_W-1:0]         res_day_q;
	logic [TEMP_W-1:0]        res_max_q;
	logic [TEMP_W-1:0]        res_min_q;
	logic [CNT_OUT_W-1:0]     res_count_q;
	logic                     res_last_q;
	logic                     ret_eos_q;

	summary_t out_q;
	logic     out_valid_q;

	leap_st_t leap_st;
	div_st_t  div_st;

	logic                       accept;
	logic                       valid_ts;
	logic                       date_change;
	logic                       inwin;
	logic signed [SUM_BITS-1:0] base_sum;
	logic signed [TEMP_W-1:0]   base_min;
	logic signed [TEMP_W-1:0]   base_max;
	logic [COUNT_BITS-1:0]      base_count;
	logic signed [SUM_BITS-1:0] acc_sum;
	logic signed [TEMP_W-1:0]   acc_min;
	logic signed [TEMP_W-1:0]   acc_max;
	logic [COUNT_BITS-1:0]      acc_count;
	logic                       snap_change;
	logic                       snap_eos;
	logic                       snap;
	logic                       slot_free;
	logic                       load_out;

	assign accept        = samples.valid && (state_q == S_IDLE);
	assign samples.ready = (state_q == S_IDLE);

	always_comb begin
		valid_ts = (in_month_q != '0) && (in_month_q <= LAST_MONTH) && (in_day_q != '0)
			&& (in_day_q <= month_length(in_month_q, leap_st.leap))
			&& (in_hour_q <= LAST_HOUR) && (in_min_q <= LAST_MIN) && (in_sec_q <= LAST_SEC);
		date_change = have_day_q && ((in_year_q != stored_year_q)
			|| (in_month_q != stored_month_q) || (in_day_q != stored_day_q));
		inwin = (in_temp_q >= low_q) && (in_temp_q <= high_q);

		// a date change starts the new day from cleared accumulators
		if (date_change) begin
			base_sum   = '0;
			base_min   = MIN_RESET;
			base_max   = MAX_RESET;
			base_count = '0;
		end else begin
			base_sum   = day_sum_q;
			base_min   = day_min_q;
			base_max   = day_max_q;
			base_count = day_count_q;
		end

		acc_sum   = base_sum;
		acc_min   = base_min;
		acc_max   = base_max;
		acc_count = base_count;
		if (inwin) begin
			if (in_temp_q < base_min)
				acc_min = in_temp_q;
			if (in_temp_q > base_max)
				acc_max = in_temp_q;
			// saturated count freezes the sum as well
			if (base_count != {COUNT_BITS{1'b1}}) begin
				acc_sum   = base_sum + SUM_BITS'(in_temp_q);
				acc_count = base_count + 1'b1;
			end
		end

		snap_change = (state_q == S_LEAP) && leap_st.done && valid_ts && date_change;
		snap_eos    = (state_q == S_EOS) && in_eos_q && have_day_q && (day_count_q != '0);
		snap        = snap_change || snap_eos;
		slot_free   = !out_valid_q || summaries.ready;
		load_out    = (state_q == S_DIV) && div_st.done && slot_free;
	end

	dts_leap u_leap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.year   (samples.year),
		.st     (leap_st)
	);

	dts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (snap),
		.sum    (day_sum_q),
		.count  (day_count_q),
		.st     (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			low_q          <= LOW_RESET;
			high_q         <= HIGH_RESET;
			stored_year_q  <= '0;
			stored_month_q <= '0;
			stored_day_q   <= '0;
			have_day_q     <= 1'b0;
			day_sum_q      <= '0;
			day_min_q      <= MIN_RESET;
			day_max_q      <= MAX_RESET;
			day_count_q    <= '0;
			ret_eos_q      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LOW_LIMIT:  low_q  <= cfg_data;
					REG_HIGH_LIMIT: high_q <= cfg_data;
					default: ;
				endcase
			end

			if (load_out)
				out_valid_q <= 1'b1;
			else if (summaries.ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_LEAP;
				end
				S_LEAP: begin
					if (leap_st.done) begin
						if (valid_ts) begin
							stored_year_q  <= in_year_q;
							stored_month_q <= in_month_q;
							stored_day_q   <= in_day_q;
							have_day_q     <= 1'b1;
							day_sum_q      <= acc_sum;
							day_min_q      <= acc_min;
							day_max_q      <= acc_max;
							day_count_q    <= acc_count;
						end
						if (snap_change) begin
							ret_eos_q <= 1'b1;
							state_q   <= S_DIV;
						end else begin
							state_q <= S_EOS;
						end
					end
				end
				S_EOS: begin
					if (in_eos_q) begin
						have_day_q  <= 1'b0;
						day_sum_q   <= '0;
						day_min_q   <= MIN_RESET;
						day_max_q   <= MAX_RESET;
						day_count_q <= '0;
					end
					if (snap_eos) begin
						ret_eos_q <= 1'b0;
						state_q   <= S_DIV;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (load_out)
						state_q <= ret_eos_q ? S_EOS : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_year_q  <= samples.year;
			in_month_q <= samples.month;
			in_day_q   <= samples.day;
			in_hour_q  <= samples.hour;
			in_min_q   <= samples.minute;
			in_sec_q   <= samples.second;
			in_temp_q  <= samples.temperature;
			in_eos_q   <= samples.end_of_stream;
		end
		if (snap) begin
			res_year_q  <= stored_year_q;
			res_month_q <= stored_month_q;
			res_day_q   <= stored_day_q;
			res_max_q   <= day_max_q;
			res_min_q   <= day_min_q;
			res_count_q <= count_out(day_count_q);
			// a flush follows only if the new day already holds a counted sample
			res_last_q  <= snap_change ? !(in_eos_q && inwin) : 1'b1;
		end
		if (load_out) begin
			out_q.summary_year  <= res_year_q;
			out_q.summary_month <= res_month_q;
			out_q.summary_day   <= res_day_q;
			out_q.max_temp      <= res_max_q;
			out_q.min_temp      <= res_min_q;
			out_q.mean_temp     <= div_st.mean;
			out_q.sample_count  <= res_count_q;
			out_q.last_of_run   <= res_last_q;
		end
	end

	assign summaries.valid         = out_valid_q;
	assign summaries.summary_year  = out_q.summary_year;
	assign summaries.summary_month = out_q.summary_month;
	assign summaries.summary_day   = out_q.summary_day;
	assign summaries.max_temp      = out_q.max_temp;
	assign summaries.min_temp      = out_q.min_temp;
	assign summaries.mean_temp     = out_q.mean_temp;
	assign summaries.sample_count  = out_q.sample_count;
	assign summaries.last_of_run   = out_q.last_of_run;

	`DTS_ASSERT_NEXT(a_accept_starts_check, clk, arst_n, samples.valid && samples.ready, state_q == S_LEAP)
	`DTS_ASSERT_IMP(a_leap_done_in_check, clk, arst_n, leap_st.done, state_q == S_LEAP)
	`DTS_ASSERT_IMP(a_no_day_is_empty, clk, arst_n, !have_day_q, (day_count_q == '0) && (day_sum_q == '0))
	`DTS_ASSERT_IMP(a_min_not_above_max, clk, arst_n, day_count_q != '0, day_min_q <= day_max_q)
	`DTS_ASSERT_NEXT(a_load_shows_result, clk, arst_n, load_out, summaries.valid)

endmodule
